/* sv/gtm_pkg.sv */
// gtm_pkg: widths, register map, reset values and shared types for the
// greedy target-mean node placement block
// no dependencies
package gtm_pkg;

    // node slots held in the state memory
    localparam int NODE_SLOTS = 16;

    // field widths
    localparam int LEN_W     = 20;
    localparam int TARGET_W  = 20;
    localparam int MAXREQ_W  = 11;
    localparam int NIU_W     = 5;
    localparam int TOT_W     = 30;
    localparam int REQCNT_W  = 11;
    localparam int TALLY_W   = 16;
    localparam int NODE_W    = 4;

    // derived arithmetic widths
    localparam int NUM_W     = TOT_W + 1;          // new total, capacity, T*n, deviation
    localparam int PROD_W    = NUM_W + REQCNT_W;   // deviation times count
    localparam int WORD_W    = TOT_W + REQCNT_W;   // memory word: {count, total}

    // slot index and count widths
    localparam int SLOT_IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(NODE_SLOTS + 1);
    localparam int ACT_W      = (SLOT_CNT_W > NIU_W) ? SLOT_CNT_W : NIU_W;

    // stream payload widths
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // apb
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAXREQ = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NODES  = 2'd2;

    localparam logic [TARGET_W-1:0] TARGET_RST = 20'd4096;
    localparam logic [MAXREQ_W-1:0] MAXREQ_RST = 11'd64;
    localparam logic [NIU_W-1:0]    NODES_RST  = 5'd16;

    localparam logic [TALLY_W-1:0]  TALLY_MAX  = '1;

    // one node entry on its way into the scan pipeline
    typedef struct packed {
        logic                  vld;
        logic                  first;
        logic                  last;
        logic [SLOT_IDX_W-1:0] idx;
        logic [TOT_W-1:0]      total;
        logic [REQCNT_W-1:0]   count;
    } scan_item_t;

    // outcome of one scan over the nodes
    typedef struct packed {
        logic                  done;
        logic                  found;
        logic [SLOT_IDX_W-1:0] idx;
        logic [TOT_W-1:0]      total;
        logic [REQCNT_W-1:0]   count;
    } scan_res_t;

endpackage

/* sv/greedy_target_mean_node_placement.sv */
// greedy_target_mean_node_placement: top level with apb registers, control
// sequencer, node state memory and result register; uses gtm_pkg, gtm_ram,
// gtm_scan
//
// usage
//   s_* channel carries one request length per transfer, m_* channel returns
//   one result per request: placed flag, chosen node, leftover tally.
//   the apb port holds target mean length, request limit per node and nodes
//   in use; write it only while no request is in flight.
// sequencing
//   one request at a time. with A = min(nodes_in_use, NODE_SLOTS), the result
//   is loaded into the output register once the scan over the A nodes is
//   through, or straight from the finish state when A is zero; the next
//   request is taken the cycle after. the scan is one memory read per node
//   through a read, rate, deviation, compare pipeline; write-back goes with the load.
// reset
//   rst_n clears the registers to their reset values, the tally to zero and
//   the per-node valid bits, so every node reads as empty; no clearing pass.
// stall
//   a finished result waits in the output register while m_tready is low;
//   a new request is still accepted and scanned, and only its write-back
//   waits until the register is free.
module greedy_target_mean_node_placement
    import gtm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [19:0] request_length, rest zero
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [0] placed, [4:1] chosen_node,
                                           // [20:5] leftover_count, rest zero
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // configuration registers
    logic [TARGET_W-1:0] target_reg;
    logic [MAXREQ_W-1:0] maxreq_reg;
    logic [NIU_W-1:0]    nodes_reg;

    // sequencer and per-request registers
    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      len_reg;
    logic [NUM_W-1:0]      cap_reg;
    logic [SLOT_IDX_W-1:0] idx_reg, last_idx_reg;
    logic                  empty_reg;
    logic [NODE_SLOTS-1:0] valid_bits_reg;
    logic [TALLY_W-1:0]    tally_reg, tally_next;
    scan_item_t            tag_reg, tag_next;

    // output register
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;

    // memory and scan signals
    logic                  ram_we, ram_re;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata;
    scan_item_t            item;
    scan_res_t             res;

    logic                  cfg_wr, in_xfer, out_free, fin_go, fin_found;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [ACT_W-1:0]      active;
    logic [NODE_W-1:0]     node_out;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign cfg_wr   = psel && penable && pwrite && pready;

    // apb read mux, unmapped addresses read zero
    always_comb
    begin
        case (reg_idx)
            REG_TARGET: prdata = PDATA_W'(target_reg);
            REG_MAXREQ: prdata = PDATA_W'(maxreq_reg);
            REG_NODES:  prdata = PDATA_W'(nodes_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            maxreq_reg <= MAXREQ_RST;
            nodes_reg  <= NODES_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_TARGET: target_reg <= pwdata[TARGET_W-1:0];
                REG_MAXREQ: maxreq_reg <= pwdata[MAXREQ_W-1:0];
                REG_NODES:  nodes_reg  <= pwdata[NIU_W-1:0];
                default:    ;
            endcase
        end
    end

    // nodes taking part, clipped to the slots that exist
    always_comb
    begin
        if (ACT_W'(nodes_reg) > ACT_W'(NODE_SLOTS))
        begin
            active = ACT_W'(NODE_SLOTS);
        end
        else
        begin
            active = ACT_W'(nodes_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign fin_go    = (state_reg == ST_FINISH) && out_free;
    assign fin_found = res.found && !empty_reg;

    // tally saturates at its top value
    always_comb
    begin
        tally_next = tally_reg;
        if (!fin_found && (tally_reg != TALLY_MAX))
        begin
            tally_next = tally_reg + TALLY_W'(1);
        end
    end

    assign node_out = fin_found ? NODE_W'(res.idx) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (active == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (res.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read tag, aligned with the registered memory data
    always_comb
    begin
        tag_next.vld   = (state_reg == ST_SCAN);
        tag_next.first = (idx_reg == '0);
        tag_next.last  = (idx_reg == last_idx_reg);
        tag_next.idx   = idx_reg;
        tag_next.total = '0;
        tag_next.count = '0;
        // total field carries the valid bit of the entry
        tag_next.total[0] = valid_bits_reg[idx_reg];
    end

    assign ram_re = (state_reg == ST_SCAN);
    assign ram_we = fin_go && fin_found;
    assign ram_wdata = {res.count, res.total};

    // entries never written read as an empty node
    always_comb
    begin
        item       = tag_reg;
        item.total = tag_reg.total[0] ? ram_rdata[TOT_W-1:0] : '0;
        item.count = tag_reg.total[0] ? ram_rdata[WORD_W-1:TOT_W] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_bits_reg <= '0;
            tally_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            tag_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tag_reg   <= tag_next;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= M_DATA_W'({tally_next, node_out, fin_found});
                tally_reg     <= tally_next;
                if (fin_found)
                begin
                    valid_bits_reg[res.idx] <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            len_reg      <= s_tdata[LEN_W-1:0];
            cap_reg      <= NUM_W'(NUM_W'(maxreq_reg) * NUM_W'(target_reg));
            last_idx_reg <= SLOT_IDX_W'(active - ACT_W'(1));
            idx_reg      <= '0;
            empty_reg    <= (active == '0);
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + SLOT_IDX_W'(1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    gtm_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (NODE_SLOTS),
        .ADDR_W (SLOT_IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (res.idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    gtm_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .len     (len_reg),
        .cap     (cap_reg),
        .target  (target_reg),
        .max_req (maxreq_reg),
        .res     (res)
    );

endmodule

/* sv/gtm_ram.sv */
// gtm_ram: generic single-write, single-read synchronous memory,
// read data registered; no dependencies
module gtm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/gtm_scan.sv */
// gtm_scan: three-stage pipeline that rates each node entry against the
// target mean and keeps the best eligible node; uses gtm_pkg
module gtm_scan
    import gtm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  scan_item_t          item,
    input  logic [LEN_W-1:0]    len,
    input  logic [NUM_W-1:0]    cap,
    input  logic [TARGET_W-1:0] target,
    input  logic [MAXREQ_W-1:0] max_req,
    output scan_res_t           res
);

    // stage 1: new total, eligibility, target times new count
    logic                  s1_vld_reg, s1_first_reg, s1_last_reg, s1_elig_reg;
    logic [SLOT_IDX_W-1:0] s1_idx_reg;
    logic [NUM_W-1:0]      s1_total_reg, s1_tn_reg;
    logic [REQCNT_W-1:0]   s1_n_reg;

    // stage 2: absolute deviation
    logic                  s2_vld_reg, s2_first_reg, s2_last_reg, s2_elig_reg;
    logic [SLOT_IDX_W-1:0] s2_idx_reg;
    logic [NUM_W-1:0]      s2_total_reg, s2_num_reg;
    logic [REQCNT_W-1:0]   s2_n_reg;

    // best so far
    logic                  found_reg, done_reg;
    logic [SLOT_IDX_W-1:0] best_idx_reg;
    logic [NUM_W-1:0]      best_num_reg, best_total_reg;
    logic [REQCNT_W-1:0]   best_den_reg;

    logic [NUM_W-1:0]      new_total;
    logic                  elig;
    logic [REQCNT_W-1:0]   n_next;
    logic [NUM_W-1:0]      tn_next;
    logic [NUM_W-1:0]      num_next;
    logic [PROD_W-1:0]     p_new, p_best;
    logic                  found_eff, take;

    always_comb
    begin
        new_total = NUM_W'(item.total) + NUM_W'(len);
        elig      = !new_total[NUM_W-1] && (new_total <= cap)
                    && (MAXREQ_W'(item.count) < max_req);
        n_next    = item.count + REQCNT_W'(1);
        tn_next   = NUM_W'(NUM_W'(target) * NUM_W'(n_next));
    end

    always_comb
    begin
        num_next = (s1_total_reg >= s1_tn_reg) ? (s1_total_reg - s1_tn_reg)
                                               : (s1_tn_reg - s1_total_reg);
    end

    always_comb
    begin
        p_new     = PROD_W'(PROD_W'(s2_num_reg) * PROD_W'(best_den_reg));
        p_best    = PROD_W'(PROD_W'(best_num_reg) * PROD_W'(s2_n_reg));
        found_eff = found_reg && !s2_first_reg;
        take      = s2_vld_reg && s2_elig_reg && (!found_eff || (p_new < p_best));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= item.vld;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg && s2_last_reg;
            if (s2_vld_reg)
            begin
                found_reg <= found_eff || take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= item.first;
        s1_last_reg  <= item.last;
        s1_idx_reg   <= item.idx;
        s1_elig_reg  <= elig;
        s1_total_reg <= new_total;
        s1_n_reg     <= n_next;
        s1_tn_reg    <= tn_next;

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_elig_reg  <= s1_elig_reg;
        s2_total_reg <= s1_total_reg;
        s2_n_reg     <= s1_n_reg;
        s2_num_reg   <= num_next;

        if (take)
        begin
            best_idx_reg   <= s2_idx_reg;
            best_num_reg   <= s2_num_reg;
            best_den_reg   <= s2_n_reg;
            best_total_reg <= s2_total_reg;
        end
    end

    always_comb
    begin
        res.done  = done_reg;
        res.found = found_reg;
        res.idx   = best_idx_reg;
        res.total = best_total_reg[TOT_W-1:0];
        res.count = best_den_reg;
    end

endmodule

/* sv/gtm_checker.sv */
// gtm_port_checks: port-level assertions for the placement block and the
// bind that attaches them; uses gtm_pkg
module gtm_port_checks
    import gtm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is in flight");

    // an unplaced result names node zero
    a_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[4:1] == '0))
        else $error("unplaced result with nonzero node");

    // a new result appears only after a request was taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready || $past(!s_tready))
        else $error("result without a request");

    // payload bits above the fields stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_DATA_W-1:21] == '0))
        else $error("nonzero padding in result");

endmodule

bind greedy_target_mean_node_placement gtm_port_checks u_checker (.*);

/* dv/gtm_checker.sv */
`timescale 1ns / 1ps
// gtm_checker: watches the request, result and apb channels of the node
// placement block, predicts every result and compares it; uses gtm_pkg
module gtm_checker
    import gtm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [19:0] request_length
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // [0] placed, [4:1] chosen_node,
                                           // [20:5] leftover_count
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    output int                  mismatch_count,
    output int                  results_owed
);

    typedef struct packed {
        logic               placed;
        logic [NODE_W-1:0]  node;
        logic [TALLY_W-1:0] tally;
    } placement_t;

    localparam longint unsigned TOTAL_LIMIT = (64'd1 << TOT_W) - 1;

    logic [TARGET_W-1:0] target_mean;
    logic [MAXREQ_W-1:0] request_limit;
    logic [NIU_W-1:0]    active_nodes;
    logic [TOT_W-1:0]    token_total [NODE_SLOTS];
    logic [REQCNT_W-1:0] request_count [NODE_SLOTS];
    logic [TALLY_W-1:0]  leftover_tally;
    placement_t          placements_due [$];

    // picks the eligible node whose new mean lies closest to the target,
    // lowest index on a tie, and books the request there
    function automatic placement_t place_request(input logic [LEN_W-1:0] len);
        placement_t      outcome;
        longint unsigned capacity;
        longint unsigned new_total;
        longint unsigned new_count;
        longint unsigned target_sum;
        longint unsigned deviation;
        longint unsigned lead_dev;
        longint unsigned best_count;
        int              scan_nodes;
        int              best;
        bit              found;
        capacity   = request_limit;
        capacity   = capacity * target_mean;
        scan_nodes = (active_nodes > NODE_SLOTS) ? NODE_SLOTS : int'(active_nodes);
        found      = 1'b0;
        best       = 0;
        lead_dev   = 0;
        best_count = 1;
        for (int j = 0; j < scan_nodes; j++)
        begin
            new_total = token_total[j];
            new_total = new_total + len;
            if (new_total > capacity || new_total > TOTAL_LIMIT)
                continue;
            if (request_count[j] >= request_limit)
                continue;
            new_count  = request_count[j];
            new_count  = new_count + 1;
            target_sum = new_count * target_mean;
            deviation  = (new_total >= target_sum) ? new_total - target_sum
                                                   : target_sum - new_total;
            // exact cross-multiplied compare of the two mean deviations
            if (!found || deviation * best_count < lead_dev * new_count)
            begin
                found      = 1'b1;
                best       = j;
                lead_dev   = deviation;
                best_count = new_count;
            end
        end
        if (found)
        begin
            token_total[best]   = token_total[best] + len;
            request_count[best] = request_count[best] + 1'b1;
            outcome.placed      = 1'b1;
            outcome.node        = best[NODE_W-1:0];
        end
        else
        begin
            if (leftover_tally != TALLY_MAX)
                leftover_tally = leftover_tally + 1'b1;
            outcome.placed = 1'b0;
            outcome.node   = '0;
        end
        outcome.tally = leftover_tally;
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        placement_t due;
        placement_t seen;
        if (!rst_n)
        begin
            target_mean    = TARGET_RST;
            request_limit  = MAXREQ_RST;
            active_nodes   = NODES_RST;
            leftover_tally = '0;
            for (int j = 0; j < NODE_SLOTS; j++)
            begin
                token_total[j]   = '0;
                request_count[j] = '0;
            end
            placements_due.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            // a result leaving now belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                seen.placed = m_tdata[0];
                seen.node   = m_tdata[NODE_W:1];
                seen.tally  = m_tdata[NODE_W+TALLY_W:NODE_W+1];
                if (placements_due.size() == 0)
                begin
                    $error("result transfer with no request pending: %s %0d %0d %0d",
                           "placed node tally", seen.placed, seen.node, seen.tally);
                    mismatch_count++;
                end
                else
                begin
                    due = placements_due.pop_front();
                    if (seen.placed !== due.placed)
                    begin
                        $error("placed: expected %0d, actual %0d", due.placed, seen.placed);
                        mismatch_count++;
                    end
                    if (seen.node !== due.node)
                    begin
                        $error("chosen_node: expected %0d, actual %0d", due.node, seen.node);
                        mismatch_count++;
                    end
                    if (seen.tally !== due.tally)
                    begin
                        $error("leftover_count: expected %0d, actual %0d",
                               due.tally, seen.tally);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                due            = place_request(s_tdata[LEN_W-1:0]);
                placements_due = {placements_due, due};
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_TARGET: target_mean   = pwdata[TARGET_W-1:0];
                    REG_MAXREQ: request_limit = pwdata[MAXREQ_W-1:0];
                    REG_NODES:  active_nodes  = pwdata[NIU_W-1:0];
                    default:    ;
                endcase
            end
            results_owed = placements_due.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for greedy_target_mean_node_placement; results are
// predicted and checked by gtm_checker; uses gtm_pkg
module tb;
    import gtm_pkg::*;

    // register index with no register behind it
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // receiver hold-off used to back the block up
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 32;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // [19:0] request_length, rest zero
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // [0] placed, [4:1] chosen_node,
                                     // [20:5] leftover_count, rest zero
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  mismatch_count;
    int                  results_owed;

    // burst: no gaps on either side; hold_outputs: one long receiver stall
    bit                  burst;
    bit                  hold_outputs;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    greedy_target_mean_node_placement u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gtm_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // offer one request length, after a random gap, and hold it until the
    // transfer; valid stays high so back-to-back requests need no toggle
    task automatic push_request(input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(len);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // setup then access cycle; psel stays up so writes can follow back to
    // back, release_bus drops it after the last one
    task automatic write_reg(input logic [REG_IDX_W-1:0] reg_idx,
                             input logic [PDATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering and wait until every predicted result has gone out;
    // polled on the falling edge so the checker has already updated
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
        @(posedge clk);
    endtask

    // lengths cluster around the target so the mean compare matters, with
    // the field extremes and fully random values mixed in
    function automatic logic [LEN_W-1:0] pick_length(input logic [TARGET_W-1:0] mean);
        logic [LEN_W-1:0] len;
        case ($urandom_range(0, 9))
            0:          len = '0;
            1:          len = '1;
            2, 3, 4, 5: len = LEN_W'(mean) + LEN_W'($urandom_range(0, 8)) - LEN_W'(4);
            6, 7:       len = LEN_W'($urandom_range(0, 2 * int'(mean)));
            default:    len = LEN_W'($urandom);
        endcase
        return len;
    endfunction

    // targets rise from phase to phase so totals left by earlier phases do
    // not block placement; count limit rises too; upper pwdata bits are junk
    task automatic random_config(input int phase, output logic [TARGET_W-1:0] mean);
        int unsigned         lo;
        int unsigned         hi;
        logic [MAXREQ_W-1:0] limit;
        logic [NIU_W-1:0]    nodes;
        lo    = 16 << (3 * phase);
        hi    = (8 * lo - 1 > 1048575) ? 1048575 : 8 * lo - 1;
        mean  = TARGET_W'($urandom_range(lo, hi));
        limit = ($urandom_range(0, 5) == 0) ? MAXREQ_W'($urandom)
                                            : MAXREQ_W'($urandom_range(1, 6) + 10 * phase);
        nodes = ($urandom_range(0, 7) == 0) ? NIU_W'($urandom)
                                            : NIU_W'($urandom_range(1, 16));
        write_reg(REG_TARGET, (PDATA_W'($urandom) << TARGET_W) | PDATA_W'(mean));
        write_reg(REG_MAXREQ, (PDATA_W'($urandom) << MAXREQ_W) | PDATA_W'(limit));
        write_reg(REG_NODES,  (PDATA_W'($urandom) << NIU_W) | PDATA_W'(nodes));
        release_bus();
    endtask

    // receiver: random stall before each result, one long hold when asked
    initial
    begin : result_sink
        int unsigned stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_outputs)
            begin
                // block keeps accepting until output register and scan are full
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_outputs = 1'b0;
            end
            stall = burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [LEN_W-1:0]    opening [12];
        logic [TARGET_W-1:0] mean;
        opening = '{20'd0, 20'd0, 20'd4096, 20'd4095, 20'd4097, 20'd1, 20'd8192,
                    20'd262144, 20'd262145, 20'hFFFFF, 20'hAAAAA, 20'h55555};
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        burst        = 1'b0;
        hold_outputs = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty nodes tie and go to node 0, capacity edge at
        // 64 * 4096, lengths beyond it are left over
        foreach (opening[i])
            push_request(opening[i]);
        settle();

        // three tiny nodes: capacity 20 and two requests each, so both the
        // token limit and the count limit are hit; index 3 write is a no-op
        write_reg(REG_TARGET, 32'd10);
        write_reg(REG_MAXREQ, 32'd2);
        write_reg(REG_NODES, 32'd3);
        write_reg(REG_UNUSED, $urandom);
        release_bus();
        push_request(20'd10);
        push_request(20'd7);
        push_request(20'd13);
        push_request(20'd10);
        push_request(20'd10);
        push_request(20'd10);
        push_request(20'd10);
        push_request(20'd0);
        settle();

        // no nodes in use: every request is left over
        write_reg(REG_NODES, 32'd0);
        release_bus();
        push_request(20'd5);
        settle();

        // more nodes than slots, zero target: only zero length fits
        write_reg(REG_NODES, 32'd31);
        write_reg(REG_TARGET, 32'd0);
        write_reg(REG_MAXREQ, 32'd5);
        release_bus();
        push_request(20'd0);
        push_request(20'd1);
        settle();

        // zero count limit: nothing fits, not even zero length
        write_reg(REG_MAXREQ, 32'd0);
        release_bus();
        push_request(20'd0);
        settle();

        // random phases; two with no gaps, one with a long receiver hold
        for (int p = 0; p < 6; p++)
        begin
            random_config(p, mean);
            burst = (p == 1 || p == 4);
            if (p == 2)
                hold_outputs = 1'b1;
            repeat (65) push_request(pick_length(mean));
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial
    begin : watchdog
        #400000;
        $display("tb failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/gtm_pkg.sv
sv/gtm_ram.sv
sv/gtm_scan.sv
sv/greedy_target_mean_node_placement.sv
sv/gtm_checker.sv
dv/gtm_checker.sv
dv/tb.sv
